[rtl/qrs_pkg.sv]
// Shared types and constants for the quadratic retry scheduler.
`default_nettype none

package qrs_pkg;

    // Field widths.
    localparam int TIME_W  = 32;
    localparam int ROOT_W  = 16;
    localparam int SKIP_W  = 8;
    localparam int STEP_W  = 17;
    localparam int RETRY_W = 34;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_OFFSET  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LIFETIME = 1'b1;

    // Register values after reset.
    localparam logic [SKIP_W-1:0] SKIP_RESET     = 8'd6;
    localparam logic [TIME_W-1:0] LIFETIME_RESET = 32'd604800;

    // Item as it moves through the root stages.
    typedef struct packed {
        logic [ROOT_W-1:0] root;
        logic [TIME_W-1:0] rem;
        logic [TIME_W-1:0] birth;
        logic              expired;
    } t_root_bus;

    // Finished item.
    typedef struct packed {
        logic [RETRY_W-1:0] retry_time;
        logic [STEP_W-1:0]  retry_step;
        logic               expired;
        logic [TIME_W-1:0]  birth;
    } t_sched_out;

endpackage

`default_nettype wire

[rtl/qrs_root_stage.sv]
// One registered step of the restoring bit-by-bit square root.
`default_nettype none

module qrs_root_stage #(
    parameter int BIT = 15
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  qrs_pkg::t_root_bus  i_bus,
    output logic                o_ready,
    output logic                o_valid,
    output qrs_pkg::t_root_bus  o_bus,
    input  wire                 i_ready
);

    // Bits at or above the root width can never be set for a 32-bit age.
    localparam logic ACTIVE = (BIT < qrs_pkg::ROOT_W);
    localparam logic [33:0] LOW_TERM = ACTIVE ? (34'd1 << (2 * BIT)) : 34'd0;
    localparam logic [qrs_pkg::ROOT_W-1:0] ROOT_MASK =
        ACTIVE ? (16'd1 << BIT) : 16'd0;

    logic               r_valid;
    qrs_pkg::t_root_bus r_bus;
    qrs_pkg::t_root_bus n_bus;
    logic [33:0]        w_trial;
    logic               w_take;

    // The stage loads when empty or when its result moves on.
    assign o_ready = !r_valid || i_ready;

    // Trial term is twice the partial root shifted in, plus the new bit squared.
    always_comb begin
        w_trial = (34'(i_bus.root) << (BIT + 1)) + LOW_TERM;
        w_take  = ACTIVE && (w_trial <= {2'b00, i_bus.rem});
        n_bus   = i_bus;
        if (w_take) begin
            n_bus.root = i_bus.root | ROOT_MASK;
            n_bus.rem  = i_bus.rem - w_trial[qrs_pkg::TIME_W-1:0];
        end
    end

    // Valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_bus <= n_bus;
        end
    end

    assign o_valid = r_valid;
    assign o_bus   = r_bus;

endmodule

`default_nettype wire

[rtl/qrs_square.sv]
// Offset add, squaring and retry time sum, three register stages.
`default_nettype none

module qrs_square (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire [qrs_pkg::SKIP_W-1:0]           i_skip,
    input  wire                                 i_valid,
    input  qrs_pkg::t_root_bus                  i_bus,
    output logic                                o_ready,
    output logic                                o_valid,
    output qrs_pkg::t_sched_out                 o_res,
    input  wire                                 i_ready
);

    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic w_en1;
    logic w_en2;
    logic w_en3;

    logic [qrs_pkg::STEP_W-1:0]  r1_step;
    logic [qrs_pkg::TIME_W-1:0]  r1_birth;
    logic                        r1_expired;
    logic [qrs_pkg::STEP_W-1:0]  r2_step;
    logic [qrs_pkg::RETRY_W-1:0] r2_sq;
    logic [qrs_pkg::TIME_W-1:0]  r2_birth;
    logic                        r2_expired;
    qrs_pkg::t_sched_out         r3_res;

    // Each stage loads when empty or when its contents move on.
    assign w_en3   = !r_v3 || i_ready;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
        end
    end

    // Stage one adds the skip offset to the root.
    always_ff @(posedge i_clk) begin
        if (w_en1 && i_valid) begin
            r1_step    <= {1'b0, i_bus.root} + {9'd0, i_skip};
            r1_birth   <= i_bus.birth;
            r1_expired <= i_bus.expired;
        end
    end

    // Stage two squares the step.
    always_ff @(posedge i_clk) begin
        if (w_en2 && r_v1) begin
            r2_sq      <= 34'(r1_step) * 34'(r1_step);
            r2_step    <= r1_step;
            r2_birth   <= r1_birth;
            r2_expired <= r1_expired;
        end
    end

    // Stage three adds the birth time and holds the result.
    always_ff @(posedge i_clk) begin
        if (w_en3 && r_v2) begin
            r3_res.retry_time <= {2'b00, r2_birth} + r2_sq;
            r3_res.retry_step <= r2_step;
            r3_res.expired    <= r2_expired;
            r3_res.birth      <= r2_birth;
        end
    end

    assign o_valid = r_v3;
    assign o_res   = r3_res;

endmodule

`default_nettype wire

[rtl/quadratic_retry_scheduler.sv]
// Top level of the quadratic retry scheduler pipeline.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+---------------------------------------
//  input   | in        | i_valid / o_stall  | i_now_time, i_birth_time
//  result  | out       | o_valid / i_stall  | o_retry_time, o_retry_step, o_expired,
//          |           |                    | o_birth_echo
//  config  | in        | i_cfg_we           | i_cfg_idx, i_cfg_wdata
//
// One item per cycle while i_stall is low; the stages are one input stage, one stage per
// root bit, then offset add, square and retry sum stages.
// Reset clears every valid bit and loads skip_offset 6 and max_lifetime 604800.
// Each stage loads when empty or when it empties, so bubbles close up while the
// output is held; o_stall rises only when every stage is full and i_stall is high.
`default_nettype none

module quadratic_retry_scheduler #(
    parameter int ROOT_BITS = 16
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // Input channel.
    input  wire                                 i_valid,
    output logic                                o_stall,
    input  wire [qrs_pkg::TIME_W-1:0]           i_now_time,
    input  wire [qrs_pkg::TIME_W-1:0]           i_birth_time,
    // Result channel.
    output logic                                o_valid,
    input  wire                                 i_stall,
    output logic [qrs_pkg::RETRY_W-1:0]         o_retry_time,
    output logic [qrs_pkg::STEP_W-1:0]          o_retry_step,
    output logic                                o_expired,
    output logic [qrs_pkg::TIME_W-1:0]          o_birth_echo,
    // Configuration port.
    input  wire                                 i_cfg_we,
    input  wire [qrs_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire [qrs_pkg::TIME_W-1:0]           i_cfg_wdata
);

    logic [qrs_pkg::SKIP_W-1:0] r_skip_offset;
    logic [qrs_pkg::TIME_W-1:0] r_max_lifetime;

    logic                r_v0;
    qrs_pkg::t_root_bus  r_bus0;
    qrs_pkg::t_root_bus  n_bus0;
    logic                w_en0;

    logic                w_valid [0:ROOT_BITS];
    qrs_pkg::t_root_bus  w_bus   [0:ROOT_BITS];
    logic                w_ready [0:ROOT_BITS];
    qrs_pkg::t_sched_out w_res;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_offset  <= qrs_pkg::SKIP_RESET;
            r_max_lifetime <= qrs_pkg::LIFETIME_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                qrs_pkg::CFG_SKIP_OFFSET: begin
                    r_skip_offset <= i_cfg_wdata[qrs_pkg::SKIP_W-1:0];
                end
                qrs_pkg::CFG_MAX_LIFETIME: begin
                    r_max_lifetime <= i_cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    // Input stage: age, with a birth in the future taken as age zero, and the expiry test.
    always_comb begin
        n_bus0.root    = '0;
        n_bus0.birth   = i_birth_time;
        n_bus0.rem     = (i_birth_time > i_now_time) ? '0 : (i_now_time - i_birth_time);
        n_bus0.expired = {1'b0, i_now_time} >
                         ({1'b0, i_birth_time} + {1'b0, r_max_lifetime});
    end

    assign w_en0   = !r_v0 || w_ready[0];
    assign o_stall = !w_en0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_en0) begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en0 && i_valid) begin
            r_bus0 <= n_bus0;
        end
    end

    assign w_valid[0] = r_v0;
    assign w_bus[0]   = r_bus0;

    // One root stage per bit, most significant first.
    for (genvar k = 0; k < ROOT_BITS; k++) begin : g_root
        qrs_root_stage #(
            .BIT (ROOT_BITS - 1 - k)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .i_bus   (w_bus[k]),
            .o_ready (w_ready[k]),
            .o_valid (w_valid[k+1]),
            .o_bus   (w_bus[k+1]),
            .i_ready (w_ready[k+1])
        );
    end

    // Offset, square and retry time.
    qrs_square u_square (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_skip  (r_skip_offset),
        .i_valid (w_valid[ROOT_BITS]),
        .i_bus   (w_bus[ROOT_BITS]),
        .o_ready (w_ready[ROOT_BITS]),
        .o_valid (o_valid),
        .o_res   (w_res),
        .i_ready (!i_stall)
    );

    assign o_retry_time = w_res.retry_time;
    assign o_retry_step = w_res.retry_step;
    assign o_expired    = w_res.expired;
    assign o_birth_echo = w_res.birth;

    // Back pressure reaches the input only when a held result stalls a full pipeline.
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while the result side is free");

    // The square is never negative and the sum cannot wrap.
    a_retry_after_birth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_retry_time >= {2'b00, o_birth_echo}))
        else $error("retry time lies before birth time");

    // The step stays within the largest root plus the largest offset.
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_retry_step <= 17'd65790))
        else $error("retry step out of range");

endmodule

`default_nettype wire

[test/quadratic_retry_scheduler_test.sv]
// Self-checking testbench for the quadratic retry scheduler pipeline.
`timescale 1ns / 1ps

module quadratic_retry_scheduler_test;

    localparam int ROOT_BITS  = 16;
    localparam int PIPE_DEPTH = ROOT_BITS + 4;
    localparam int MAX_PRINTS = 40;

    // One item offered on the input channel.
    typedef struct packed {
        logic [qrs_pkg::TIME_W-1:0] now_time;
        logic [qrs_pkg::TIME_W-1:0] birth_time;
    } t_sched_req;

    typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_TOGGLE} t_rx_mode;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    logic [qrs_pkg::TIME_W-1:0]    i_now_time = '0;
    logic [qrs_pkg::TIME_W-1:0]    i_birth_time = '0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic [qrs_pkg::RETRY_W-1:0]   o_retry_time;
    logic [qrs_pkg::STEP_W-1:0]    o_retry_step;
    logic                          o_expired;
    logic [qrs_pkg::TIME_W-1:0]    o_birth_echo;
    logic                          i_cfg_we = 1'b0;
    logic [qrs_pkg::CFG_IDX_W-1:0] i_cfg_idx = qrs_pkg::CFG_SKIP_OFFSET;
    logic [qrs_pkg::TIME_W-1:0]    i_cfg_wdata = '0;

    // Local copy of the configuration registers.
    logic [qrs_pkg::SKIP_W-1:0]    skip_cfg = qrs_pkg::SKIP_RESET;
    logic [qrs_pkg::TIME_W-1:0]    lifetime_cfg = qrs_pkg::LIFETIME_RESET;

    t_sched_req                    pending_requests[$];
    qrs_pkg::t_sched_out           sched_expected[$];
    int                            items_queued = 0;
    int                            results_seen = 0;
    int                            mismatch_count = 0;
    logic                          req_taken = 1'b0;

    // Sender burst state.
    int                            burst_left = 8;
    int                            gap_left = 0;

    // Receiver stall pattern state.
    t_rx_mode                      rx_mode = RX_OPEN;
    int                            rx_mode_left = 0;
    int                            hold_left = 0;
    int                            holds_done = 0;

    quadratic_retry_scheduler #(
        .ROOT_BITS(ROOT_BITS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_now_time  (i_now_time),
        .i_birth_time(i_birth_time),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_retry_time(o_retry_time),
        .o_retry_step(o_retry_step),
        .o_expired   (o_expired),
        .o_birth_echo(o_birth_echo),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Schedule for one item: restoring root of the age, offset, square, expiry.
    function automatic qrs_pkg::t_sched_out predict_schedule(
        logic [qrs_pkg::TIME_W-1:0] now_t,
        logic [qrs_pkg::TIME_W-1:0] birth_t);
        logic [63:0] age;
        logic [63:0] root;
        logic [63:0] square;
        logic [63:0] trial;
        logic [qrs_pkg::STEP_W-1:0] step;
        logic [qrs_pkg::TIME_W:0] deadline;
        qrs_pkg::t_sched_out res;
        root = '0;
        square = '0;
        if (birth_t <= now_t) begin
            age = 64'(now_t - birth_t);
            for (int b = ROOT_BITS - 1; b >= 0; b--) begin
                trial = (root << (b + 1)) + (64'd1 << (2 * b));
                if (trial <= age - square) begin
                    root = root + (64'd1 << b);
                    square = square + trial;
                end
            end
        end
        step = qrs_pkg::STEP_W'(root) + qrs_pkg::STEP_W'(skip_cfg);
        deadline = {1'b0, birth_t} + {1'b0, lifetime_cfg};
        res.retry_time = qrs_pkg::RETRY_W'(birth_t) +
                         qrs_pkg::RETRY_W'(step) * qrs_pkg::RETRY_W'(step);
        res.retry_step = step;
        res.expired = ({1'b0, now_t} > deadline);
        res.birth = birth_t;
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatch_count < MAX_PRINTS)
            $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic queue_request(logic [qrs_pkg::TIME_W-1:0] now_t,
                                 logic [qrs_pkg::TIME_W-1:0] birth_t);
        t_sched_req req;
        req.now_time = now_t;
        req.birth_time = birth_t;
        pending_requests.push_back(req);
        items_queued++;
    endtask

    // Register write on the idle block; upper data bits carry noise on purpose.
    task automatic write_config(logic [qrs_pkg::CFG_IDX_W-1:0] idx,
                                logic [qrs_pkg::TIME_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_wdata = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == qrs_pkg::CFG_SKIP_OFFSET)
            skip_cfg = data[qrs_pkg::SKIP_W-1:0];
        else
            lifetime_cfg = data;
    endtask

    // Block until every queued item has come back as a result.
    task automatic wait_drained();
        while (results_seen != items_queued)
            @(negedge i_clk);
    endtask

    // Random item biased toward the interesting regions of the age.
    task automatic queue_random_request();
        logic [63:0] age;
        logic [63:0] root;
        logic [qrs_pkg::TIME_W-1:0] now_t;
        logic [qrs_pkg::TIME_W-1:0] birth_t;
        case ($urandom_range(0, 5))
            0: begin
                now_t = $urandom;
                birth_t = $urandom;
            end
            1: begin
                age = 64'($urandom_range(0, 1000));
                birth_t = $urandom_range(0, 32'hFFFF_FFFF - 32'(age));
                now_t = birth_t + 32'(age);
            end
            2: begin
                // Ages around a perfect square.
                root = 64'($urandom_range(0, 65535));
                age = root * root + 64'($urandom_range(0, 2));
                age = (age == 0) ? 64'd0 : age - 1;
                if (age > 64'hFFFF_FFFF)
                    age = 64'hFFFF_FFFF;
                birth_t = $urandom_range(0, 32'hFFFF_FFFF - 32'(age));
                now_t = birth_t + 32'(age);
            end
            3: begin
                // Ages around the lifetime boundary.
                age = 64'(lifetime_cfg) + 64'($urandom_range(0, 2));
                age = (age == 0) ? 64'd0 : age - 1;
                if (age > 64'hFFFF_FFFF)
                    age = 64'hFFFF_FFFF;
                birth_t = $urandom_range(0, 32'hFFFF_FFFF - 32'(age));
                now_t = birth_t + 32'(age);
            end
            4: begin
                // Birth lies in the future.
                now_t = $urandom_range(0, 32'hFFFF_FFFE);
                birth_t = now_t + 32'($urandom_range(1, 32'hFFFF_FFFF - now_t));
            end
            default: begin
                birth_t = $urandom_range(0, 255);
                now_t = 32'hFFFF_FFFF - 32'($urandom_range(0, 255));
            end
        endcase
        queue_request(now_t, birth_t);
    endtask

    // Reset is held at the start and never again.
    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    // Stimulus phases, each under its own register setting.
    initial begin
        wait (i_rst_n === 1'b1);

        // Directed items under the reset configuration.
        queue_request(32'd0, 32'd0);
        queue_request(32'hFFFF_FFFF, 32'd0);
        queue_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_request(32'd0, 32'hFFFF_FFFF);
        queue_request(32'd5, 32'd6);
        queue_request(32'd604800, 32'd0);
        queue_request(32'd604801, 32'd0);
        queue_request(32'd16, 32'd0);
        queue_request(32'd15, 32'd0);
        queue_request(32'd24, 32'd0);
        queue_request(32'd25, 32'd0);
        queue_request(32'hFFFF_FFFE, 32'd0);
        queue_request(32'h8000_0000, 32'd0);
        queue_request(32'hFFFE_0001, 32'd0);
        queue_request(32'hFFFE_0000, 32'd0);
        queue_request(32'hFFFF_FFFF, 32'd1);
        queue_request(32'hFFFF_FFFF, 32'hFFF6_C180);
        queue_request(32'hFFFF_FFFF, 32'hFFF6_C17F);
        queue_request(32'hAAAA_AAAA, 32'h5555_5555);
        queue_request(32'h5555_5555, 32'hAAAA_AAAA);
        repeat (150) queue_random_request();
        wait_drained();

        // Extreme and random register settings.
        for (int phase = 0; phase < 8; phase++) begin
            logic [qrs_pkg::SKIP_W-1:0] skip_v;
            logic [qrs_pkg::TIME_W-1:0] life_v;
            case (phase)
                0: begin skip_v = 8'd0;   life_v = 32'd0;           end
                1: begin skip_v = 8'd255; life_v = 32'hFFFF_FFFF;   end
                2: begin skip_v = 8'd255; life_v = 32'd0;           end
                3: begin skip_v = 8'd0;   life_v = 32'hFFFF_FFFF;   end
                4: begin skip_v = 8'($urandom); life_v = $urandom;  end
                default: begin
                    skip_v = 8'($urandom);
                    life_v = $urandom_range(0, 100000);
                end
            endcase
            write_config(qrs_pkg::CFG_SKIP_OFFSET, {24'($urandom), skip_v});
            write_config(qrs_pkg::CFG_MAX_LIFETIME, life_v);
            repeat (175) queue_random_request();
            wait_drained();
        end

        repeat (PIPE_DEPTH + 10) @(negedge i_clk);
        if (mismatch_count == 0 && sched_expected.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Input driver: bursts of items separated by random gaps.
    always @(negedge i_clk) begin
        t_sched_req req;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || req_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
                req = pending_requests.pop_front();
                i_valid <= 1'b1;
                i_now_time <= req.now_time;
                i_birth_time <= req.birth_time;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 32);
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: gap_left = 0;
                        4, 5, 6, 7: gap_left = $urandom_range(1, 3);
                        8:          gap_left = $urandom_range(4, 12);
                        default:    gap_left = $urandom_range(20, 40);
                    endcase
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result receiver: changing stall patterns plus two long hold-offs that fill the pipe.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (holds_done < 2 && results_seen >= 400 + 700 * holds_done) begin
            hold_left = 150;
            holds_done++;
            i_stall <= 1'b1;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(16, 96);
            end
            rx_mode_left--;
            case (rx_mode)
                RX_OPEN:  i_stall <= 1'b0;
                RX_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
                default:  i_stall <= ~i_stall;
            endcase
        end
    end

    // Monitor: predict on every accepted item, check every accepted result.
    always @(posedge i_clk) begin
        qrs_pkg::t_sched_out want;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= i_valid && !o_stall;
            // Check before predicting so a result cannot match the prediction for an item taken alongside it.
            if (o_valid && !i_stall) begin
                results_seen++;
                if (sched_expected.size() == 0) begin
                    report_mismatch("result arrived with no item outstanding");
                end else begin
                    want = sched_expected.pop_front();
                    if (o_retry_time !== want.retry_time)
                        report_mismatch($sformatf("retry_time %0d, expected %0d",
                                                  o_retry_time, want.retry_time));
                    if (o_retry_step !== want.retry_step)
                        report_mismatch($sformatf("retry_step %0d, expected %0d",
                                                  o_retry_step, want.retry_step));
                    if (o_expired !== want.expired)
                        report_mismatch($sformatf("expired %0b, expected %0b",
                                                  o_expired, want.expired));
                    if (o_birth_echo !== want.birth)
                        report_mismatch($sformatf("birth_echo %0d, expected %0d",
                                                  o_birth_echo, want.birth));
                end
            end
            if (i_valid && !o_stall)
                sched_expected.push_back(predict_schedule(i_now_time, i_birth_time));
        end
    end

    // Watchdog for a stuck pipeline.
    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
